// ----- rtl/l2lb_pkg.sv -----
// l2lb_pkg: field widths and the table entry type of the learning bridge
// used by l2_learning_bridge; no dependencies
package l2lb_pkg;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 3;
    localparam int MASK_W = 8;

    typedef logic [MAC_W-1:0]  mac_t;
    typedef logic [PORT_W-1:0] port_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        mac_t  mac;
        port_t port;
    } entry_t;

endpackage

// ----- rtl/l2lb_ram.sv -----
// l2lb_ram: generic single-clock RAM, one write and one read port, registered read
// no dependencies
module l2lb_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/l2_learning_bridge.sv -----
// Ethernet MAC learning bridge: address table in l2lb_ram, scan and learn control
// depends on l2lb_pkg and l2lb_ram
//
// Usage:
//   input channel in_valid/in_ready carries one frame header word: ingress_port,
//   dst_mac, src_mac. output channel out_valid/out_ready carries one result word:
//   egress_mask, dest_known, learn_failed. cfg_wr_en/cfg_wr_data write the flood
//   set, active_mask_reg, which the user must do only while the bridge is idle;
//   the block itself does not enforce this. entries fill from the bottom and are
//   never removed, so a fill count marks the used part of the table. each word
//   scans the used entries once through the single read port, checking source
//   and destination against every entry read, one entry per cycle. then the
//   learn-and-result cycle writes the table (rewrite, or append unless it is
//   full) and loads the result register. a word passes S_SCAN (skipped with an
//   empty table) and S_FINISH to out_valid; new words are taken only in S_IDLE.
//   the learning write lands before the next scan starts, so no forwarding.
//   reset empties the table at once (fill count cleared), sets the mask to all ones.
//   a result waiting in the output register does not stop the next scan; only the
//   learn-and-result cycle waits for the output register to free up.
module l2_learning_bridge #(
    parameter int TABLE_ENTRIES = 64,
    parameter int PORT_COUNT    = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  l2lb_pkg::mask_t        cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  l2lb_pkg::port_t        ingress_port,
    input  l2lb_pkg::mac_t         dst_mac,
    input  l2lb_pkg::mac_t         src_mac,
    output logic                   out_valid,
    input  logic                   out_ready,
    output l2lb_pkg::mask_t        egress_mask,
    output logic                   dest_known,
    output logic                   learn_failed
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(l2lb_pkg::entry_t);
    localparam l2lb_pkg::mask_t EXIST_MASK = (PORT_COUNT >= l2lb_pkg::MASK_W) ?
        {l2lb_pkg::MASK_W{1'b1}} : l2lb_pkg::mask_t'((1 << PORT_COUNT) - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              chk_valid_reg;
    logic [AW-1:0]     chk_idx_reg;
    logic              src_hit_reg, src_hit_next;
    logic [AW-1:0]     src_idx_reg, src_idx_next;
    logic              dst_hit_reg, dst_hit_next;
    l2lb_pkg::port_t   dst_port_reg, dst_port_next;
    l2lb_pkg::mask_t   active_mask_reg;
    logic              out_valid_reg, out_valid_next;

    l2lb_pkg::port_t   port_reg;
    l2lb_pkg::mac_t    dst_reg;
    l2lb_pkg::mac_t    src_reg;
    l2lb_pkg::mask_t   egress_reg;
    logic              known_reg;
    logic              failed_reg;

    logic              in_fire;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    l2lb_pkg::entry_t  rd_entry;
    logic [EW-1:0]     rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    l2lb_pkg::entry_t  wr_entry;
    logic              out_free;
    logic              finish_go;
    logic              table_full;
    logic              fail_now;
    logic              known_now;
    l2lb_pkg::port_t   hit_port;
    l2lb_pkg::mask_t   egress_now;

    l2lb_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry  = l2lb_pkg::entry_t'(rd_data);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign rd_en     = (state_reg == S_SCAN) && (issue_reg < fill_reg);
    assign rd_addr   = issue_reg[AW-1:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign finish_go = (state_reg == S_FINISH) && out_free;
    assign table_full = (fill_reg == CW'(TABLE_ENTRIES));
    assign fail_now  = !src_hit_reg && table_full;

    // a frame to its own source hits the entry just learned, unless learning failed
    always_comb
    begin
        if (dst_reg == src_reg)
        begin
            known_now = !fail_now;
            hit_port  = port_reg;
        end
        else
        begin
            known_now = dst_hit_reg;
            hit_port  = dst_port_reg;
        end
        if (known_now)
        begin
            egress_now = (l2lb_pkg::mask_t'(1) << hit_port) & EXIST_MASK;
        end
        else
        begin
            egress_now = active_mask_reg & ~(l2lb_pkg::mask_t'(1) << port_reg) & EXIST_MASK;
        end
    end

    assign wr_en        = finish_go && !fail_now;
    assign wr_addr      = src_hit_reg ? src_idx_reg : fill_reg[AW-1:0];
    assign wr_entry.mac  = src_reg;
    assign wr_entry.port = port_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        src_hit_next   = src_hit_reg;
        src_idx_next   = src_idx_reg;
        dst_hit_next   = dst_hit_reg;
        dst_port_next  = dst_port_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (rd_en)
        begin
            issue_next = issue_reg + CW'(1);
        end
        // table MACs are unique, so at most one entry matches each address
        if (chk_valid_reg)
        begin
            if (rd_entry.mac == src_reg)
            begin
                src_hit_next = 1'b1;
                src_idx_next = chk_idx_reg;
            end
            if (rd_entry.mac == dst_reg)
            begin
                dst_hit_next  = 1'b1;
                dst_port_next = rd_entry.port;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    issue_next   = '0;
                    src_hit_next = 1'b0;
                    dst_hit_next = 1'b0;
                    state_next   = (fill_reg == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!rd_en && chk_valid_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!src_hit_reg && !table_full)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            issue_reg       <= '0;
            chk_valid_reg   <= 1'b0;
            src_hit_reg     <= 1'b0;
            dst_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_mask_reg <= {l2lb_pkg::MASK_W{1'b1}};
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= rd_en;
            src_hit_reg   <= src_hit_next;
            dst_hit_reg   <= dst_hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                active_mask_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= rd_addr;
        src_idx_reg  <= src_idx_next;
        dst_port_reg <= dst_port_next;
        if (in_fire)
        begin
            port_reg <= ingress_port;
            dst_reg  <= dst_mac;
            src_reg  <= src_mac;
        end
        if (finish_go)
        begin
            egress_reg <= egress_now;
            known_reg  <= known_now;
            failed_reg <= fail_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign egress_mask  = egress_reg;
    assign dest_known   = known_reg;
    assign learn_failed = failed_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_write_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_FINISH) && !rd_en)
        else $error("table write outside learn cycle");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word loaded outside learn cycle");

    a_fail_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && failed_reg |-> fill_reg == CW'(TABLE_ENTRIES))
        else $error("learn failure reported with free entries");

    a_known_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && known_reg |-> $onehot0(egress_reg))
        else $error("known destination with several egress ports");

endmodule

// ----- tb/sv/tb_l2_learning_bridge.sv -----
// tb_l2_learning_bridge: self-checking bench for the learning bridge, frame headers in,
// forwarding decisions out, predicted by a table copy kept in the bench
// depends on l2lb_pkg and l2_learning_bridge
module tb_l2_learning_bridge;

    localparam int              TABLE_ENTRIES = 64;
    localparam int              PORT_COUNT    = 8;
    localparam int              QUIET_LIMIT   = 4000;
    localparam int              TAIL_CYCLES   = TABLE_ENTRIES + 8;
    localparam l2lb_pkg::mask_t PORT_SET      = (PORT_COUNT >= l2lb_pkg::MASK_W) ? '1
        : l2lb_pkg::mask_t'((1 << PORT_COUNT) - 1);

    typedef struct {
        l2lb_pkg::mask_t egress;
        logic            known;
        logic            failed;
    } forward_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    l2lb_pkg::mask_t cfg_wr_data;
    logic            in_valid;
    logic            in_ready;
    l2lb_pkg::port_t ingress_port;
    l2lb_pkg::mac_t  dst_mac;
    l2lb_pkg::mac_t  src_mac;
    logic            out_valid;
    logic            out_ready;
    l2lb_pkg::mask_t egress_mask;
    logic            dest_known;
    logic            learn_failed;

    // bench copy of the address table; entries fill from the bottom and stay
    l2lb_pkg::mac_t  fdb_mac  [TABLE_ENTRIES];
    l2lb_pkg::port_t fdb_port [TABLE_ENTRIES];
    int              fdb_fill;
    l2lb_pkg::mask_t flood_set;
    forward_t        pending_fwd[$];
    int              error_count = 0;
    int              burst_left  = 0;
    int              rx_hold     = 0;
    bit              rx_open;

    l2_learning_bridge #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ingress_port (ingress_port),
        .dst_mac      (dst_mac),
        .src_mac      (src_mac),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .egress_mask  (egress_mask),
        .dest_known   (dest_known),
        .learn_failed (learn_failed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int fdb_find(l2lb_pkg::mac_t mac);
        for (int i = 0; i < fdb_fill; i++)
            if (fdb_mac[i] == mac)
                return i;
        return -1;
    endfunction

    // learn the source first, then look up the destination in the updated table
    function automatic forward_t bridge_forward(l2lb_pkg::port_t port, l2lb_pkg::mac_t dst,
                                                l2lb_pkg::mac_t src);
        forward_t fwd;
        int       idx;
        fwd.known  = 1'b0;
        fwd.failed = 1'b0;
        idx = fdb_find(src);
        if (idx >= 0)
            fdb_port[idx] = port;
        else if (fdb_fill < TABLE_ENTRIES)
        begin
            fdb_mac[fdb_fill]  = src;
            fdb_port[fdb_fill] = port;
            fdb_fill++;
        end
        else
            fwd.failed = 1'b1;
        idx = fdb_find(dst);
        if (idx >= 0)
        begin
            fwd.known  = 1'b1;
            fwd.egress = (l2lb_pkg::mask_t'(1) << fdb_port[idx]) & PORT_SET;
        end
        else
            fwd.egress = flood_set & ~(l2lb_pkg::mask_t'(1) << port) & PORT_SET;
        return fwd;
    endfunction

    function automatic l2lb_pkg::mac_t random_mac();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return l2lb_pkg::mac_t'({$urandom(), $urandom()}) | 48'h0100_0000_0000;
            default: return l2lb_pkg::mac_t'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic l2lb_pkg::mac_t learned_mac();
        if (fdb_fill == 0)
            return random_mac();
        return fdb_mac[$urandom_range(0, fdb_fill - 1)];
    endfunction

    // one header word, sent in bursts with random gaps in between
    task automatic send_frame(l2lb_pkg::port_t port, l2lb_pkg::mac_t dst,
                              l2lb_pkg::mac_t src);
        int       gap;
        forward_t fwd;
        @(negedge clk);
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ingress_port <= port;
        dst_mac      <= dst;
        src_mac      <= src;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fwd = bridge_forward(port, dst, src);
        pending_fwd = {pending_fwd, fwd};
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_fwd.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_flood_set(l2lb_pkg::mask_t value);
        wait_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        flood_set = value;
    endtask

    task automatic random_frame(int fresh_pct);
        l2lb_pkg::port_t port;
        l2lb_pkg::mac_t  dst;
        l2lb_pkg::mac_t  src;
        int              pick;
        port = l2lb_pkg::port_t'($urandom_range(0, 7));
        src  = ($urandom_range(0, 99) < fresh_pct) ? random_mac() : learned_mac();
        pick = $urandom_range(0, 9);
        if (pick < 6)
            dst = learned_mac();
        else if (pick == 6)
            dst = src;
        else
            dst = random_mac();
        // now and then hold off until the bridge has answered everything
        if ($urandom_range(0, 99) == 0)
            wait_results();
        send_frame(port, dst, src);
    endtask

    task automatic test_directed_frames();
        send_frame(3'd0, '0, '1);
        send_frame(3'd7, '1, '0);
        send_frame(3'd3, '0, 48'h0180_C200_000E);
        send_frame(3'd5, 48'h0180_C200_000E, 48'h0180_C200_000E);
        send_frame(3'd2, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA);
        send_frame(3'd6, 48'h5555_5555_5555, '1);
        send_frame(3'd4, '1, 48'h5555_5555_5555);
        send_frame(3'd1, 48'h5555_5555_5555, 48'h0000_0000_0001);
        // destination learned on the ingress port itself
        send_frame(3'd1, 48'h0000_0000_0001, 48'h1234_5678_9ABC);
    endtask

    task automatic test_flood_masks();
        write_flood_set(8'h00);
        send_frame(3'd1, 48'h0200_5E00_0001, '0);
        send_frame(3'd2, '1, '0);
        // ingress port outside the flood set
        write_flood_set(8'h0F);
        send_frame(3'd6, 48'h0200_5E00_0002, '1);
        send_frame(3'd2, 48'h0200_5E00_0003, '1);
        write_flood_set(8'h80);
        send_frame(3'd7, 48'h0200_5E00_0004, 48'h5555_5555_5555);
        write_flood_set(8'h55);
        send_frame(3'd0, 48'h0200_5E00_0005, 48'hAAAA_AAAA_AAAA);
        send_frame(3'd3, 48'h0200_5E00_0006, 48'hAAAA_AAAA_AAAA);
        write_flood_set(8'hFF);
    endtask

    task automatic test_random_learning();
        repeat (600)
            random_frame(8);
    endtask

    task automatic test_table_full();
        l2lb_pkg::mac_t stray;
        while (fdb_fill < TABLE_ENTRIES)
            send_frame(l2lb_pkg::port_t'($urandom_range(0, 7)), learned_mac(), random_mac());
        // new source addressed to itself is neither stored nor found
        stray = l2lb_pkg::mac_t'({$urandom(), $urandom()});
        send_frame(3'd4, stray, stray);
        send_frame(3'd5, learned_mac(), l2lb_pkg::mac_t'({$urandom(), $urandom()}));
        stray = learned_mac();
        send_frame(3'd3, stray, stray);
    endtask

    task automatic test_random_full_table();
        repeat (3)
        begin
            write_flood_set(l2lb_pkg::mask_t'($urandom_range(0, 255)));
            repeat (300)
                random_frame(30);
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_open = ($urandom_range(0, 2) != 0);
            rx_hold = rx_open ? $urandom_range(1, 60) : $urandom_range(1, 12);
        end
        rx_hold--;
        out_ready <= rx_open;
    end

    always @(posedge clk)
    begin : check_word
        forward_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fwd.size() == 0)
            begin
                $error("result word with no frame waiting");
                error_count++;
            end
            else
            begin
                want = pending_fwd.pop_front();
                if (egress_mask !== want.egress)
                begin
                    $error("egress_mask: expected %h, got %h", want.egress, egress_mask);
                    error_count++;
                end
                if (dest_known !== want.known)
                begin
                    $error("dest_known: expected %b, got %b", want.known, dest_known);
                    error_count++;
                end
                if (learn_failed !== want.failed)
                begin
                    $error("learn_failed: expected %b, got %b", want.failed, learn_failed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        ingress_port = '0;
        dst_mac      = '0;
        src_mac      = '0;
        fdb_fill     = 0;
        flood_set    = 8'hFF;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_flood_masks();
        test_random_learning();
        test_table_full();
        test_random_full_table();

        wait_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_fwd.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
